FILE: rtl/clip_sequence_voice_mixer_assert.svh
// assertion macros for the mixer rtl
`ifndef CLIP_SEQUENCE_VOICE_MIXER_ASSERT_SVH
`define CLIP_SEQUENCE_VOICE_MIXER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CSVM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvm same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define CSVM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvm next-cycle check failed");

`endif

FILE: rtl/csvm_pkg.sv
`default_nettype none

package csvm_pkg;

    // sizes
    localparam int CLIP_COUNT   = 64;
    localparam int CLIP_WORDS   = 2048;
    localparam int MAX_VOICES   = 8;
    localparam int MAX_SEQUENCE = 64;

    localparam int CLIP_W   = (CLIP_COUNT > 1) ? $clog2(CLIP_COUNT) : 1;
    localparam int WORD_W   = $clog2(CLIP_WORDS);
    localparam int LEN_W    = $clog2(CLIP_WORDS + 1);
    localparam int VOICE_W  = $clog2(MAX_VOICES + 1);
    localparam int VIDX_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int REGIONS  = MAX_VOICES + 1;
    localparam int REG_W    = $clog2(REGIONS);
    localparam int SEQ_AW   = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
    localparam int PLEN_W   = $clog2(MAX_SEQUENCE + 1);

    // operation codes on the input tuser
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_LENGTH = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_COMMIT = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_VOICE_DROP = 2'd1;
    localparam logic [1:0] ST_SYM_DROP   = 2'd2;

    localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

    // classified work item
    typedef enum logic [2:0] {
        K_NOP,
        K_WRITE,
        K_LENGTH,
        K_APPEND,
        K_COMMIT,
        K_TICK
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [CLIP_W-1:0]       clip;
        logic [WORD_W-1:0]       word;
        logic signed [15:0]      sample;
        logic [LEN_W-1:0]        len;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

`default_nettype wire

FILE: rtl/clip_sequence_voice_mixer.sv
// clip_sequence_voice_mixer: sample-playback voice mixer
// s_axis: one beat per item; tuser carries the operation (write word,
//   set length, append symbol, commit voice, tick), tdata the operands.
// m_axis: exactly one beat per input item, in order: the mixed sample
//   (zero except on tick), the count of voices still playing and a status.
// sequence: an item is taken in S_IDLE, executed in S_EXEC and output
//   from S_DONE; append reads the clip length in S_APP first, a tick
//   walks each playing voice through S_TV, S_TSYM, S_TLEN and S_TWORD.
// throughput: one item at a time in the back end, set by the voice walk
//   through the symbol, length and clip word memories, one read each;
//   a two-beat queue keeps s_axis_tready high while it has room.
// reset: voice table and pending voice empty, all clip lengths zero at
//   once through per-clip valid bits; clip words stay undefined until
//   written, no clearing pass.
// stall: a held m_axis beat stays stable; the back end finishes its next
//   item and waits, the queue fills, then s_axis_tready drops.
`default_nettype none

module clip_sequence_voice_mixer (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // clip_id, word_index, sample_value, clip_length, symbol, zero pad
    input  wire logic [55:0]  s_axis_tdata,
    // operation
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // mixed_sample, active_voice_count, status, zero pad
    output logic [23:0]       m_axis_tdata
);

    csvm_pkg::q_head_t   head;
    logic                pop;
    logic signed [15:0]  mix;
    logic [3:0]          vcount;
    logic [1:0]          status;

    // accept and classify
    csvm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .head     (head),
        .pop      (pop)
    );

    // execute and mix
    csvm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (mix),
        .out_count  (vcount),
        .out_status (status)
    );

    // result beat packing
    assign m_axis_tdata = {2'b00, status, vcount, mix};

`include "clip_sequence_voice_mixer_assert.svh"

    // checks
    `CSVM_ASSERT_IMP(a_pop_has_item, pop, head.valid)
    `CSVM_ASSERT_NXT(a_one_item_in_flight, pop, !pop)
    `CSVM_ASSERT_IMP(a_count_bound, m_axis_tvalid, int'(vcount) <= csvm_pkg::MAX_VOICES)
    `CSVM_ASSERT_IMP(a_drop_no_mix, m_axis_tvalid && status != csvm_pkg::ST_OK, mix == 16'sd0)

endmodule

`default_nettype wire

FILE: rtl/csvm_front.sv
`default_nettype none

module csvm_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          in_op,
    input  wire logic [55:0]         in_data,
    output csvm_pkg::q_head_t        head,
    input  wire logic                pop
);

    logic [5:0]          f_clip_id;
    logic [10:0]         f_word_index;
    logic signed [15:0]  f_sample;
    logic [11:0]         f_clip_length;
    logic [7:0]          f_symbol;
    csvm_pkg::item_t     cls;

    csvm_pkg::item_t     q_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                push;

    // unpack the beat
    assign f_clip_id     = in_data[5:0];
    assign f_word_index  = in_data[16:6];
    assign f_sample      = in_data[32:17];
    assign f_clip_length = in_data[44:33];
    assign f_symbol      = in_data[52:45];

    // classify the item, range checks and length clamp
    always_comb
    begin
        cls        = '0;
        cls.kind   = csvm_pkg::K_NOP;
        cls.sample = f_sample;
        cls.word   = csvm_pkg::WORD_W'(f_word_index);
        cls.clip   = csvm_pkg::CLIP_W'(f_clip_id);
        cls.len    = (int'(f_clip_length) > csvm_pkg::CLIP_WORDS)
                     ? csvm_pkg::LEN_W'(csvm_pkg::CLIP_WORDS)
                     : csvm_pkg::LEN_W'(f_clip_length);
        unique case (in_op)
            csvm_pkg::OP_WRITE:
            begin
                if (int'(f_clip_id) < csvm_pkg::CLIP_COUNT &&
                    int'(f_word_index) < csvm_pkg::CLIP_WORDS)
                    cls.kind = csvm_pkg::K_WRITE;
            end
            csvm_pkg::OP_LENGTH:
            begin
                if (int'(f_clip_id) < csvm_pkg::CLIP_COUNT)
                    cls.kind = csvm_pkg::K_LENGTH;
            end
            csvm_pkg::OP_APPEND:
            begin
                cls.clip = csvm_pkg::CLIP_W'(f_symbol);
                if (int'(f_symbol) < csvm_pkg::CLIP_COUNT)
                    cls.kind = csvm_pkg::K_APPEND;
            end
            csvm_pkg::OP_COMMIT: cls.kind = csvm_pkg::K_COMMIT;
            csvm_pkg::OP_TICK:   cls.kind = csvm_pkg::K_TICK;
            default:             cls.kind = csvm_pkg::K_NOP;
        endcase
    end

    // two-entry queue toward the back end
    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

`default_nettype wire

FILE: rtl/csvm_back.sv
`default_nettype none

module csvm_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire csvm_pkg::q_head_t   head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [15:0]       out_sample,
    output logic [3:0]               out_count,
    output logic [1:0]               out_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_APP,
        S_TV,
        S_TSYM,
        S_TLEN,
        S_TWORD,
        S_DONE
    } state_t;

    localparam int CLIP_DEPTH = csvm_pkg::CLIP_COUNT << csvm_pkg::WORD_W;
    localparam int SYM_DEPTH  = csvm_pkg::REGIONS << csvm_pkg::SEQ_AW;
    localparam int CLIP_AW    = csvm_pkg::CLIP_W + csvm_pkg::WORD_W;
    localparam int SYM_AW     = csvm_pkg::REG_W + csvm_pkg::SEQ_AW;

    // memories
    logic signed [15:0]          clip_mem [CLIP_DEPTH];
    logic [csvm_pkg::LEN_W-1:0]  lens_mem [csvm_pkg::CLIP_COUNT];
    logic [csvm_pkg::CLIP_W-1:0] sym_mem  [SYM_DEPTH];
    logic                        lens_valid_reg [csvm_pkg::CLIP_COUNT];

    logic signed [15:0]          word_rd_reg;
    logic [csvm_pkg::LEN_W-1:0]  len_rd_reg;
    logic                        lenv_rd_reg;
    logic [csvm_pkg::CLIP_W-1:0] sym_rd_reg;

    logic                        clip_we, len_we, sym_we;
    logic [CLIP_AW-1:0]          clip_raddr;
    logic [csvm_pkg::CLIP_W-1:0] len_raddr;
    logic [SYM_AW-1:0]           sym_raddr, sym_waddr;

    // control and working registers
    state_t                       state_reg, state_next;
    csvm_pkg::item_t              item_reg, item_next;
    logic [1:0]                   status_reg, status_next;
    logic signed [15:0]           acc_reg, acc_next;
    logic [csvm_pkg::VOICE_W-1:0] vidx_reg, vidx_next;
    logic [csvm_pkg::VOICE_W-1:0] count_reg, count_next;
    logic [csvm_pkg::PLEN_W-1:0]  pos_reg, pos_next;
    logic [csvm_pkg::WORD_W-1:0]  off_reg, off_next;
    logic [csvm_pkg::CLIP_W-1:0]  clip_reg, clip_next;
    logic [csvm_pkg::LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic [csvm_pkg::PLEN_W-1:0]  pend_len_reg, pend_len_next;
    logic [csvm_pkg::REG_W-1:0]   pend_rgn_reg, pend_rgn_next;

    // voice table, kept compacted oldest first
    logic [csvm_pkg::REG_W-1:0]   rec_rgn_reg [csvm_pkg::MAX_VOICES];
    logic [csvm_pkg::REG_W-1:0]   rec_rgn_next [csvm_pkg::MAX_VOICES];
    logic [csvm_pkg::PLEN_W-1:0]  rec_seq_reg [csvm_pkg::MAX_VOICES];
    logic [csvm_pkg::PLEN_W-1:0]  rec_seq_next [csvm_pkg::MAX_VOICES];
    logic [csvm_pkg::PLEN_W-1:0]  rec_pos_reg [csvm_pkg::MAX_VOICES];
    logic [csvm_pkg::PLEN_W-1:0]  rec_pos_next [csvm_pkg::MAX_VOICES];
    logic [csvm_pkg::WORD_W-1:0]  rec_off_reg [csvm_pkg::MAX_VOICES];
    logic [csvm_pkg::WORD_W-1:0]  rec_off_next [csvm_pkg::MAX_VOICES];

    logic                         out_valid_reg, out_valid_next;
    logic signed [15:0]           out_sample_reg, out_sample_next;
    logic [3:0]                   out_count_reg, out_count_next;
    logic [1:0]                   out_status_reg, out_status_next;

    logic [csvm_pkg::VIDX_W-1:0]  vi;
    logic [csvm_pkg::LEN_W-1:0]   len_eff;
    logic [csvm_pkg::PLEN_W-1:0]  pos_inc;
    logic [csvm_pkg::LEN_W-1:0]   off_inc;
    logic signed [16:0]           sum;
    logic signed [15:0]           sum_sat;
    logic                         fin;
    logic [csvm_pkg::PLEN_W-1:0]  fin_pos;
    logic [csvm_pkg::WORD_W-1:0]  fin_off;
    logic                         used [csvm_pkg::REGIONS];
    logic [csvm_pkg::REG_W-1:0]   free_rgn;

    assign vi      = vidx_reg[csvm_pkg::VIDX_W-1:0];
    assign len_eff = lenv_rd_reg ? len_rd_reg : '0;
    assign pos_inc = pos_reg + 1'b1;
    assign off_inc = csvm_pkg::LEN_W'(off_reg) + 1'b1;
    assign sym_waddr = {pend_rgn_reg, pend_len_reg[csvm_pkg::SEQ_AW-1:0]};

    // saturating accumulate
    always_comb
    begin
        sum = {acc_reg[15], acc_reg} + {word_rd_reg[15], word_rd_reg};
        if (sum[16] != sum[15])
            sum_sat = sum[16] ? csvm_pkg::SAT_MIN : csvm_pkg::SAT_MAX;
        else
            sum_sat = sum[15:0];
    end

    // region not held by a playing voice nor the pending one
    always_comb
    begin
        for (int r = 0; r < csvm_pkg::REGIONS; r++)
            used[r] = 1'b0;
        used[pend_rgn_reg] = 1'b1;
        for (int k = 0; k < csvm_pkg::MAX_VOICES; k++)
        begin
            if (k < int'(count_reg))
                used[rec_rgn_reg[k]] = 1'b1;
        end
        free_rgn = '0;
        for (int r = csvm_pkg::REGIONS - 1; r >= 0; r--)
        begin
            if (!used[r])
                free_rgn = csvm_pkg::REG_W'(r);
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        acc_next        = acc_reg;
        vidx_next       = vidx_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        off_next        = off_reg;
        clip_next       = clip_reg;
        cur_len_next    = cur_len_reg;
        pend_len_next   = pend_len_reg;
        pend_rgn_next   = pend_rgn_reg;
        rec_rgn_next    = rec_rgn_reg;
        rec_seq_next    = rec_seq_reg;
        rec_pos_next    = rec_pos_reg;
        rec_off_next    = rec_off_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        pop             = 1'b0;
        clip_we         = 1'b0;
        len_we          = 1'b0;
        sym_we          = 1'b0;
        clip_raddr      = '0;
        len_raddr       = '0;
        sym_raddr       = '0;
        fin             = 1'b0;
        fin_pos         = pos_reg;
        fin_off         = off_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    item_next   = head.item;
                    status_next = csvm_pkg::ST_OK;
                    acc_next    = '0;
                    vidx_next   = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (item_reg.kind)
                    csvm_pkg::K_WRITE:  clip_we = 1'b1;
                    csvm_pkg::K_LENGTH: len_we = 1'b1;
                    csvm_pkg::K_APPEND:
                    begin
                        len_raddr  = item_reg.clip;
                        state_next = S_APP;
                    end
                    csvm_pkg::K_COMMIT:
                    begin
                        if (pend_len_reg != '0)
                        begin
                            if (count_reg >= csvm_pkg::VOICE_W'(csvm_pkg::MAX_VOICES))
                                status_next = csvm_pkg::ST_VOICE_DROP;
                            else
                            begin
                                rec_rgn_next[count_reg[csvm_pkg::VIDX_W-1:0]] = pend_rgn_reg;
                                rec_seq_next[count_reg[csvm_pkg::VIDX_W-1:0]] = pend_len_reg;
                                rec_pos_next[count_reg[csvm_pkg::VIDX_W-1:0]] = '0;
                                rec_off_next[count_reg[csvm_pkg::VIDX_W-1:0]] = '0;
                                count_next    = count_reg + 1'b1;
                                pend_rgn_next = free_rgn;
                            end
                        end
                        pend_len_next = '0;
                    end
                    csvm_pkg::K_TICK: state_next = S_TV;
                    default:          state_next = S_DONE;
                endcase
            end
            S_APP:
            begin
                if (len_eff != '0)
                begin
                    if (pend_len_reg >= csvm_pkg::PLEN_W'(csvm_pkg::MAX_SEQUENCE))
                        status_next = csvm_pkg::ST_SYM_DROP;
                    else
                    begin
                        sym_we        = 1'b1;
                        pend_len_next = pend_len_reg + 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_TV:
            begin
                if (vidx_reg >= count_reg)
                    state_next = S_DONE;
                else
                begin
                    pos_next = rec_pos_reg[vi];
                    off_next = rec_off_reg[vi];
                    if (rec_pos_reg[vi] < rec_seq_reg[vi])
                    begin
                        sym_raddr  = {rec_rgn_reg[vi],
                                      rec_pos_reg[vi][csvm_pkg::SEQ_AW-1:0]};
                        state_next = S_TSYM;
                    end
                    else
                    begin
                        fin     = 1'b1;
                        fin_pos = rec_pos_reg[vi];
                        fin_off = rec_off_reg[vi];
                    end
                end
            end
            S_TSYM:
            begin
                clip_next  = sym_rd_reg;
                len_raddr  = sym_rd_reg;
                state_next = S_TLEN;
            end
            S_TLEN:
            begin
                cur_len_next = len_eff;
                if (csvm_pkg::LEN_W'(off_reg) < len_eff)
                begin
                    clip_raddr = {clip_reg, off_reg};
                    state_next = S_TWORD;
                end
                else
                begin
                    // clip used up or shortened: skip to the next one
                    pos_next = pos_inc;
                    off_next = '0;
                    if (pos_inc < rec_seq_reg[vi])
                    begin
                        sym_raddr  = {rec_rgn_reg[vi], pos_inc[csvm_pkg::SEQ_AW-1:0]};
                        state_next = S_TSYM;
                    end
                    else
                    begin
                        fin     = 1'b1;
                        fin_pos = pos_inc;
                        fin_off = '0;
                    end
                end
            end
            S_TWORD:
            begin
                acc_next = sum_sat;
                fin      = 1'b1;
                if (off_inc >= cur_len_reg)
                begin
                    fin_pos = pos_inc;
                    fin_off = '0;
                end
                else
                begin
                    fin_pos = pos_reg;
                    fin_off = off_inc[csvm_pkg::WORD_W-1:0];
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = acc_reg;
                    out_count_next  = 4'(count_reg);
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // voice finished for this tick: store progress or free it
        if (fin)
        begin
            state_next = S_TV;
            if (fin_pos >= rec_seq_reg[vi])
            begin
                for (int k = 0; k < csvm_pkg::MAX_VOICES - 1; k++)
                begin
                    if (k >= int'(vi))
                    begin
                        rec_rgn_next[k] = rec_rgn_reg[k + 1];
                        rec_seq_next[k] = rec_seq_reg[k + 1];
                        rec_pos_next[k] = rec_pos_reg[k + 1];
                        rec_off_next[k] = rec_off_reg[k + 1];
                    end
                end
                count_next = count_reg - 1'b1;
            end
            else
            begin
                rec_pos_next[vi] = fin_pos;
                rec_off_next[vi] = fin_off;
                vidx_next        = vidx_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_len_reg  <= '0;
            pend_rgn_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < csvm_pkg::CLIP_COUNT; c++)
                lens_valid_reg[c] <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_len_reg  <= pend_len_next;
            pend_rgn_reg  <= pend_rgn_next;
            out_valid_reg <= out_valid_next;
            if (len_we)
                lens_valid_reg[item_reg.clip] <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        status_reg     <= status_next;
        acc_reg        <= acc_next;
        vidx_reg       <= vidx_next;
        pos_reg        <= pos_next;
        off_reg        <= off_next;
        clip_reg       <= clip_next;
        cur_len_reg    <= cur_len_next;
        rec_rgn_reg    <= rec_rgn_next;
        rec_seq_reg    <= rec_seq_next;
        rec_pos_reg    <= rec_pos_next;
        rec_off_reg    <= rec_off_next;
        out_sample_reg <= out_sample_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    // clip word store
    always_ff @(posedge clk)
    begin
        if (clip_we)
            clip_mem[{item_reg.clip, item_reg.word}] <= item_reg.sample;
        word_rd_reg <= clip_mem[clip_raddr];
    end

    // clip length store
    always_ff @(posedge clk)
    begin
        if (len_we)
            lens_mem[item_reg.clip] <= item_reg.len;
        len_rd_reg  <= lens_mem[len_raddr];
        lenv_rd_reg <= lens_valid_reg[len_raddr];
    end

    // symbol store, one region per voice plus the pending one
    always_ff @(posedge clk)
    begin
        if (sym_we)
            sym_mem[sym_waddr] <= item_reg.clip;
        sym_rd_reg <= sym_mem[sym_raddr];
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    // one expected output beat
    typedef struct packed {
        logic signed [15:0] mix;
        logic [3:0]         count;
        logic [1:0]         status;
    } mix_result_t;

    // one input beat
    typedef struct packed {
        logic [2:0]         op;
        logic [5:0]         clip;
        logic [10:0]        word;
        logic signed [15:0] sample;
        logic [11:0]        len;
        logic [7:0]         sym;
    } mix_item_t;

    // directed row: item plus optional typed-in result
    typedef struct {
        mix_item_t   item;
        bit          has_fixed;
        mix_result_t fixed;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    clip_sequence_voice_mixer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // mirror of the mixer state
    logic signed [15:0] clip_mem [csvm_pkg::CLIP_COUNT*csvm_pkg::CLIP_WORDS];
    bit                 clip_written [csvm_pkg::CLIP_COUNT*csvm_pkg::CLIP_WORDS];
    int                 clip_len [csvm_pkg::CLIP_COUNT];
    int                 voice_syms [csvm_pkg::MAX_VOICES][csvm_pkg::MAX_SEQUENCE];
    int                 voice_len [csvm_pkg::MAX_VOICES];
    int                 voice_pos [csvm_pkg::MAX_VOICES];
    int                 voice_off [csvm_pkg::MAX_VOICES];
    int                 voice_count;
    int                 pend_syms [csvm_pkg::MAX_SEQUENCE];
    int                 pend_len;

    mix_result_t expected_beats [$];
    int          fail_count;
    int          idle_send_pct;
    int          idle_recv_pct;
    int          quiet_cycles = 0;

    function automatic int sat_add(int a, int b);
        int s;
        s = a + b;
        if (s > 32767) return 32767;
        if (s < -32768) return -32768;
        return s;
    endfunction

    function automatic void remove_voice(int v);
        for (int k = v; k + 1 < voice_count; k++) begin
            voice_syms[k] = voice_syms[k+1];
            voice_len[k]  = voice_len[k+1];
            voice_pos[k]  = voice_pos[k+1];
            voice_off[k]  = voice_off[k+1];
        end
        voice_count--;
        voice_len[voice_count] = 0;
        voice_pos[voice_count] = 0;
        voice_off[voice_count] = 0;
    endfunction

    // advance all voices by one sample and return the saturated mix
    function automatic int mix_tick();
        int acc;
        int v;
        int clip;
        int len;
        int pos;
        int off;
        acc = 0;
        v = 0;
        while (v < voice_count) begin
            pos = voice_pos[v];
            off = voice_off[v];
            clip = 0;
            len = 0;
            while (pos < voice_len[v]) begin
                clip = voice_syms[v][pos] % csvm_pkg::CLIP_COUNT;
                len = clip_len[clip];
                if (off < len) break;
                pos++;
                off = 0;
            end
            if (pos < voice_len[v]) begin
                acc = sat_add(acc, int'(clip_mem[clip*csvm_pkg::CLIP_WORDS + off]));
                off++;
                if (off >= len) begin
                    pos++;
                    off = 0;
                end
            end
            voice_pos[v] = pos;
            voice_off[v] = off;
            if (pos >= voice_len[v]) remove_voice(v);
            else v++;
        end
        return acc;
    endfunction

    function automatic mix_result_t predict_mix(mix_item_t it);
        mix_result_t r;
        r.mix = '0;
        r.status = csvm_pkg::ST_OK;
        case (it.op)
            csvm_pkg::OP_WRITE:
            begin
                clip_mem[int'(it.clip)*csvm_pkg::CLIP_WORDS + int'(it.word)] = it.sample;
                clip_written[int'(it.clip)*csvm_pkg::CLIP_WORDS + int'(it.word)] = 1'b1;
            end
            csvm_pkg::OP_LENGTH:
                clip_len[it.clip] = (int'(it.len) > csvm_pkg::CLIP_WORDS)
                                    ? csvm_pkg::CLIP_WORDS : int'(it.len);
            csvm_pkg::OP_APPEND:
            begin
                if (int'(it.sym) < csvm_pkg::CLIP_COUNT && clip_len[it.sym] != 0) begin
                    if (pend_len >= csvm_pkg::MAX_SEQUENCE) r.status = csvm_pkg::ST_SYM_DROP;
                    else pend_syms[pend_len++] = int'(it.sym);
                end
            end
            csvm_pkg::OP_COMMIT:
            begin
                if (pend_len != 0) begin
                    if (voice_count >= csvm_pkg::MAX_VOICES) r.status = csvm_pkg::ST_VOICE_DROP;
                    else begin
                        for (int i = 0; i < pend_len; i++)
                            voice_syms[voice_count][i] = pend_syms[i];
                        voice_len[voice_count] = pend_len;
                        voice_pos[voice_count] = 0;
                        voice_off[voice_count] = 0;
                        voice_count++;
                    end
                end
                pend_len = 0;
            end
            csvm_pkg::OP_TICK: r.mix = 16'(mix_tick());
            default: ;
        endcase
        r.count = 4'(voice_count);
        return r;
    endfunction

    // send one beat, predict it when accepted
    task automatic send_item(mix_item_t it, bit has_fixed, mix_result_t fixed);
        mix_result_t r;
        while (idle_send_pct > 0 && $urandom_range(99) < idle_send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {3'b000, it.sym, it.len, it.sample, it.word, it.clip};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        r = predict_mix(it);
        if (has_fixed && r !== fixed) begin
            $display("%0t directed row disagrees: typed %p predicted %p", $time, fixed, r);
            fail_count++;
        end
        expected_beats.insert(expected_beats.size(), has_fixed ? fixed : r);
        @(negedge clk);
    endtask

    task automatic send_pred(mix_item_t it);
        mix_result_t none;
        none = '0;
        send_item(it, 1'b0, none);
    endtask

    function automatic mix_item_t mk(logic [2:0] op, int clip, int word, int sample,
                                     int len, int sym);
        mix_item_t it;
        it.op = op;
        it.clip = 6'(clip);
        it.word = 11'(word);
        it.sample = 16'(sample);
        it.len = 12'(len);
        it.sym = 8'(sym);
        return it;
    endfunction

    // random noise in unused fields
    function automatic mix_item_t rnd_fields(logic [2:0] op);
        return mk(op, $urandom_range(63), $urandom_range(2047), $urandom_range(65535),
                  $urandom_range(4095), $urandom_range(255));
    endfunction

    // fill a clip with words and set its length
    task automatic load_clip(int clip, int len);
        mix_item_t it;
        for (int w = 0; w < len; w++) begin
            it = rnd_fields(csvm_pkg::OP_WRITE);
            it.clip = 6'(clip);
            it.word = 11'(w);
            case ($urandom_range(5))
                0: it.sample = 16'sh7FFF;
                1: it.sample = 16'sh8000;
                default: ;
            endcase
            send_pred(it);
        end
        it = rnd_fields(csvm_pkg::OP_LENGTH);
        it.clip = 6'(clip);
        it.len = 12'(len);
        send_pred(it);
    endtask

    // true when every word below len of the clip was written
    function automatic bit clip_safe(int clip, int len);
        for (int w = 0; w < len && w < csvm_pkg::CLIP_WORDS; w++)
            if (!clip_written[clip*csvm_pkg::CLIP_WORDS + w]) return 1'b0;
        return 1'b1;
    endfunction

    // sender drops valid and holds off until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
    endtask

    // output beat checker
    always @(posedge clk) begin
        mix_result_t got;
        mix_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mix    = m_axis_tdata[15:0];
            got.count  = m_axis_tdata[19:16];
            got.status = m_axis_tdata[21:20];
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected beat: actual %p", $time, got);
                fail_count++;
            end
            else begin
                want = expected_beats.pop_front();
                if (got.mix !== want.mix) begin
                    $display("%0t mixed_sample: expected %0d actual %0d",
                             $time, want.mix, got.mix);
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t voice count: expected %0d actual %0d",
                             $time, want.count, got.count);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk) begin
        m_axis_tready <= !(idle_recv_pct > 0 && $urandom_range(99) < idle_recv_pct);
    end

    // watchdog on accepted beats
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    dir_row_t dir_rows [$];
    mix_item_t it;
    int sent;
    int phase_len;
    int clip;
    int len;

    function automatic void add_row(mix_item_t it, bit fx, int mix, int cnt, int st);
        dir_row_t d;
        d.item = it;
        d.has_fixed = fx;
        d.fixed.mix = 16'(mix);
        d.fixed.count = 4'(cnt);
        d.fixed.status = 2'(st);
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    initial begin
        fail_count = 0;
        voice_count = 0;
        pend_len = 0;
        foreach (clip_len[i]) clip_len[i] = 0;
        foreach (voice_len[i]) begin
            voice_len[i] = 0;
            voice_pos[i] = 0;
            voice_off[i] = 0;
        end
        idle_send_pct = 22;
        idle_recv_pct = 57;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        add_row(mk(csvm_pkg::OP_TICK, 0, 0, 0, 0, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_APPEND, 0, 0, 0, 0, 5), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_COMMIT, 0, 0, 0, 0, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_WRITE, 5, 0, 32767, 0, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_WRITE, 5, 1, -32768, 0, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_WRITE, 63, 2047, -1, 0, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_LENGTH, 5, 0, 0, 2, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_LENGTH, 63, 0, 0, 4095, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_APPEND, 0, 0, 0, 0, 255), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_APPEND, 0, 0, 0, 0, 5), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_COMMIT, 0, 0, 0, 0, 0), 1, 0, 1, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_APPEND, 0, 0, 0, 0, 5), 1, 0, 1, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_COMMIT, 0, 0, 0, 0, 0), 1, 0, 2, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_TICK, 0, 0, 0, 0, 0), 1, 32767, 2, csvm_pkg::ST_OK);
        add_row(mk(csvm_pkg::OP_TICK, 0, 0, 0, 0, 0), 1, -32768, 0, csvm_pkg::ST_OK);
        add_row(mk(3'd5, 0, 0, 0, 0, 0), 1, 0, 0, csvm_pkg::ST_OK);
        add_row(mk(3'd7, 63, 2047, -1, 4095, 255), 1, 0, 0, csvm_pkg::ST_OK);
        // shortened clip while playing: voice freed without a sample
        add_row(mk(csvm_pkg::OP_APPEND, 0, 0, 0, 0, 5), 0, 0, 0, 0);
        add_row(mk(csvm_pkg::OP_COMMIT, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk(csvm_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk(csvm_pkg::OP_LENGTH, 5, 0, 0, 1, 0), 0, 0, 0, 0);
        add_row(mk(csvm_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].has_fixed, dir_rows[i].fixed);

        // sequence full: 65 appends of a valid clip, then commit
        for (int i = 0; i < csvm_pkg::MAX_SEQUENCE + 1; i++)
            send_pred(mk(csvm_pkg::OP_APPEND, 0, 0, 0, 0, 5));
        send_pred(mk(csvm_pkg::OP_COMMIT, 0, 0, 0, 0, 0));
        // table full: nine voices in all, the last one dropped
        for (int v = 0; v < csvm_pkg::MAX_VOICES; v++) begin
            send_pred(mk(csvm_pkg::OP_APPEND, 0, 0, 0, 0, 5));
            send_pred(mk(csvm_pkg::OP_COMMIT, 0, 0, 0, 0, 0));
        end
        for (int i = 0; i < 3; i++) send_pred(mk(csvm_pkg::OP_TICK, 0, 0, 0, 0, 0));

        // sender holds off until the pipe is empty
        wait_drained();

        // random part in three idling phases
        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                idle_send_pct = 57;
                idle_recv_pct = 22;
            end
            if (ph == 2) begin
                idle_send_pct = 0;
                idle_recv_pct = 0;
            end
            phase_len = sent + 100;
            while (sent < phase_len) begin
                case ($urandom_range(9))
                    0:
                    begin
                        // short clip loaded in full
                        clip = $urandom_range(15);
                        len = $urandom_range(1, 6);
                        load_clip(clip, len);
                        sent += len + 1;
                    end
                    1, 2:
                    begin
                        // build a voice from playable clips
                        for (int s = $urandom_range(1, 4); s > 0; s--) begin
                            it = rnd_fields(csvm_pkg::OP_APPEND);
                            it.sym = 8'($urandom_range(15));
                            if (clip_len[it.sym] == 0 || clip_safe(it.sym, clip_len[it.sym]))
                                send_pred(it);
                            sent++;
                        end
                        send_pred(rnd_fields(csvm_pkg::OP_COMMIT));
                        sent++;
                    end
                    3, 4, 5:
                    begin
                        send_pred(rnd_fields(csvm_pkg::OP_TICK));
                        sent++;
                    end
                    6:
                    begin
                        // noise: stray writes, out-of-range appends, unknown ops
                        it = rnd_fields(3'($urandom_range(5, 7)));
                        if ($urandom_range(1)) begin
                            it = rnd_fields(csvm_pkg::OP_WRITE);
                            it.clip = 6'($urandom_range(16, 63));
                        end
                        else if ($urandom_range(1)) begin
                            it = rnd_fields(csvm_pkg::OP_APPEND);
                            it.sym = 8'($urandom_range(64, 255));
                        end
                        send_pred(it);
                        sent++;
                    end
                    7:
                    begin
                        // length change only where every word is written
                        it = rnd_fields(csvm_pkg::OP_LENGTH);
                        it.clip = 6'($urandom_range(15));
                        if ($urandom_range(3) == 0) it.len = '0;
                        else it.len = 12'($urandom_range(1, 6));
                        if (clip_safe(it.clip, it.len)) send_pred(it);
                        sent++;
                    end
                    default:
                    begin
                        send_pred(rnd_fields(csvm_pkg::OP_COMMIT));
                        sent++;
                    end
                endcase
            end
        end

        // wait for the tail with a limit
        fork
            wait_drained();
            begin
                repeat (200000) @(posedge clk);
            end
        join_any
        disable fork;
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_beats.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
